### src/mfde_pkg.sv
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int unsigned ScreenWidthDef  = 128;
  localparam int unsigned ScreenHeightDef = 64;

  // Command codes as they arrive on the op port.
  typedef enum logic [2:0] {
    OP_PIXEL  = 3'd0,
    OP_LINE   = 3'd1,
    OP_CIRCLE = 3'd2,
    OP_RECT   = 3'd3,
    OP_FILL   = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  // Classified command kind handed from the front to the back.
  typedef enum logic [2:0] {
    KIND_PIXEL,
    KIND_LINE,
    KIND_CIRCLE,
    KIND_RECT,
    KIND_FILL,
    KIND_READ,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [7:0]  radius;
    logic        color;
    logic [9:0]  byte_index;
  } cmd_t;

endpackage

### src/mfde_front.sv
// ----------------------------------------------------------------------------
// mfde_front
// Accepts commands, classifies the op code and queues them for the back end.
// ----------------------------------------------------------------------------
module mfde_front
  import mfde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  op_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  end_x_i,
  input  logic [7:0]  end_y_i,
  input  logic [7:0]  radius_i,
  input  logic        color_i,
  input  logic [9:0]  byte_index_i,
  output logic        busy_o,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_ready_i
);

  cmd_t       fifo_q [2];
  cmd_t       in_cmd;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  always_comb begin
    case (op_i)
      OP_PIXEL:  in_cmd.kind = KIND_PIXEL;
      OP_LINE:   in_cmd.kind = KIND_LINE;
      OP_CIRCLE: in_cmd.kind = KIND_CIRCLE;
      OP_RECT:   in_cmd.kind = KIND_RECT;
      OP_FILL:   in_cmd.kind = KIND_FILL;
      OP_READ:   in_cmd.kind = KIND_READ;
      default:   in_cmd.kind = KIND_NOP;
    endcase
    in_cmd.pos_x      = pos_x_i;
    in_cmd.pos_y      = pos_y_i;
    in_cmd.end_x      = end_x_i;
    in_cmd.end_y      = end_y_i;
    in_cmd.radius     = radius_i;
    in_cmd.color      = color_i;
    in_cmd.byte_index = byte_index_i;
  end

  assign busy_o      = count_q[1];
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = start_i && !busy_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

### src/mfde_back.sv
// ----------------------------------------------------------------------------
// mfde_back
// Executes queued commands: plots pixels and walks lines, rectangles and circles
// pixel by pixel with read-modify-write on the framebuffer, sweeps fills, and reads.
// ----------------------------------------------------------------------------
module mfde_back
  import mfde_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        invert_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_ready_o,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        is_read_o
);

  localparam int unsigned PageCount  = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned StoreBytes = SCREEN_WIDTH * PageCount;
  localparam int unsigned AddrW      = $clog2(StoreBytes);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_WR,
    S_NEXT,
    S_FILL,
    S_RDATA
  } state_e;

  state_e            state_q;
  kind_e             kind_q;
  logic [7:0]        px_q, py_q, ex_q, ey_q, rad_q;
  logic              color_q;
  logic [9:0]        bidx_q;
  logic [7:0]        plot_x_q, plot_y_q;
  // Line walker
  logic [7:0]        ax_q, ay_q, bx_q, by_q, dx_q, dy_q;
  logic              sx_q, sy_q, first_q;
  logic signed [10:0] err_q;
  logic [1:0]        seg_q;
  // Circle walker
  logic signed [12:0] cx_q, cy_q, cerr_q;
  logic [1:0]        quad_q;
  logic [AddrW-1:0]  fill_cnt_q;
  logic              done_q, is_read_q;
  logic [7:0]        rdata_q;

  // Framebuffer port
  logic [7:0]        mem_q [StoreBytes];
  logic [7:0]        mem_rd_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic [7:0]        mem_wdata;

  logic              color_eff;
  logic              plot_off;
  logic [AddrW-1:0]  pix_addr, read_addr;
  logic              read_in_range;
  logic [7:0]        bit_mask;

  // Segment loader
  logic [1:0]        seg_n;
  logic [7:0]        sa_x, sa_y, sb_x, sb_y;
  logic [7:0]        ld_dx, ld_dy;
  logic              ld_sx, ld_sy;
  logic signed [10:0] ld_err;

  // Line step
  logic signed [11:0] twice;
  logic              step_x, step_y;
  logic signed [10:0] err_a, err_n;
  logic [7:0]        ax_n, ay_n;

  // Circle step
  logic              y_inc, x_inc;
  logic signed [12:0] cy1, cx1, cerr1, cerr2, e2b;
  logic [7:0]        q_x, q_y, q0_x, q0_y;

  function automatic logic [15:0] circ_pt(input logic [1:0] q, input logic [7:0] cx,
                                          input logic [7:0] cy, input logic [7:0] xl,
                                          input logic [7:0] yl);
    logic [7:0] ox, oy;
    case (q)
      2'd0:    begin ox = cx - xl; oy = cy + yl; end
      2'd1:    begin ox = cx + xl; oy = cy + yl; end
      2'd2:    begin ox = cx + xl; oy = cy - yl; end
      default: begin ox = cx - xl; oy = cy - yl; end
    endcase
    return {ox, oy};
  endfunction

  assign cmd_ready_o = (state_q == S_IDLE);
  assign color_eff   = color_q ^ invert_i;
  assign plot_off    = (32'(plot_x_q) >= SCREEN_WIDTH) || (32'(plot_y_q) >= SCREEN_HEIGHT);
  assign pix_addr    = AddrW'(32'(plot_x_q) + 32'(plot_y_q[7:3]) * SCREEN_WIDTH);
  assign read_addr   = AddrW'(bidx_q);
  assign read_in_range = (32'(bidx_q) < StoreBytes);
  assign bit_mask    = 8'd1 << plot_y_q[2:0];

  always_comb begin
    seg_n = (state_q == S_START) ? 2'd0 : seg_q + 2'd1;
    sa_x = px_q; sa_y = py_q; sb_x = ex_q; sb_y = ey_q;
    if (kind_q == KIND_RECT) begin
      case (seg_n)
        2'd0:    begin sa_x = px_q; sa_y = py_q; sb_x = ex_q; sb_y = py_q; end
        2'd1:    begin sa_x = ex_q; sa_y = py_q; sb_x = ex_q; sb_y = ey_q; end
        2'd2:    begin sa_x = ex_q; sa_y = ey_q; sb_x = px_q; sb_y = ey_q; end
        default: begin sa_x = px_q; sa_y = ey_q; sb_x = px_q; sb_y = py_q; end
      endcase
    end
    ld_sx  = (sa_x < sb_x);
    ld_sy  = (sa_y < sb_y);
    ld_dx  = ld_sx ? sb_x - sa_x : sa_x - sb_x;
    ld_dy  = ld_sy ? sb_y - sa_y : sa_y - sb_y;
    ld_err = $signed({3'b000, ld_dx}) - $signed({3'b000, ld_dy});
  end

  always_comb begin
    twice  = {err_q, 1'b0};
    step_x = (twice > -$signed({4'b0000, dy_q}));
    step_y = (twice < $signed({4'b0000, dx_q}));
    err_a  = step_x ? err_q - $signed({3'b000, dy_q}) : err_q;
    err_n  = step_y ? err_a + $signed({3'b000, dx_q}) : err_a;
    ax_n   = step_x ? (sx_q ? ax_q + 8'd1 : ax_q - 8'd1) : ax_q;
    ay_n   = step_y ? (sy_q ? ay_q + 8'd1 : ay_q - 8'd1) : ay_q;
  end

  always_comb begin
    y_inc = (cerr_q <= cy_q);
    cy1   = y_inc ? cy_q + 13'sd1 : cy_q;
    cerr1 = y_inc ? cerr_q + (cy1 <<< 1) + 13'sd1 : cerr_q;
    // The error term is forced to zero on the diagonal to avoid a doubled step.
    e2b   = (y_inc && (-cx_q == cy1) && (cerr_q <= cx_q)) ? 13'sd0 : cerr_q;
    x_inc = (e2b > cx_q);
    cx1   = x_inc ? cx_q + 13'sd1 : cx_q;
    cerr2 = x_inc ? cerr1 + (cx1 <<< 1) + 13'sd1 : cerr1;
    {q_x, q_y}   = circ_pt(quad_q + 2'd1, px_q, py_q, cx_q[7:0], cy_q[7:0]);
    {q0_x, q0_y} = circ_pt(2'd0, px_q, py_q, cx1[7:0], cy1[7:0]);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pix_addr;
    mem_wdata = color_eff ? (mem_rd_q | bit_mask) : (mem_rd_q & ~bit_mask);
    case (state_q)
      S_START: begin
        if (kind_q == KIND_READ && read_in_range) begin
          mem_re   = 1'b1;
          mem_addr = read_addr;
        end
      end
      S_RD: mem_re = !plot_off;
      S_WR: mem_we = 1'b1;
      S_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = fill_cnt_q;
        mem_wdata = color_q ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      is_read_q <= 1'b0;
      rdata_q   <= 8'h00;
    end else begin
      done_q    <= 1'b0;
      is_read_q <= 1'b0;
      rdata_q   <= 8'h00;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            kind_q  <= cmd_i.kind;
            px_q    <= cmd_i.pos_x;
            py_q    <= cmd_i.pos_y;
            ex_q    <= cmd_i.end_x;
            ey_q    <= cmd_i.end_y;
            rad_q   <= cmd_i.radius;
            color_q <= cmd_i.color;
            bidx_q  <= cmd_i.byte_index;
            state_q <= S_START;
          end
        end
        S_START: begin
          case (kind_q)
            KIND_PIXEL: begin
              plot_x_q <= px_q;
              plot_y_q <= py_q;
              state_q  <= S_RD;
            end
            KIND_LINE, KIND_RECT: begin
              seg_q    <= seg_n;
              ax_q     <= sa_x;
              ay_q     <= sa_y;
              bx_q     <= sb_x;
              by_q     <= sb_y;
              dx_q     <= ld_dx;
              dy_q     <= ld_dy;
              sx_q     <= ld_sx;
              sy_q     <= ld_sy;
              err_q    <= ld_err;
              first_q  <= 1'b1;
              plot_x_q <= sb_x;
              plot_y_q <= sb_y;
              state_q  <= S_RD;
            end
            KIND_CIRCLE: begin
              if ((32'(px_q) >= SCREEN_WIDTH) || (32'(py_q) >= SCREEN_HEIGHT)) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                cx_q     <= -$signed({5'b00000, rad_q});
                cy_q     <= 13'sd0;
                cerr_q   <= 13'sd2 - $signed({4'b0000, rad_q, 1'b0});
                quad_q   <= 2'd0;
                {plot_x_q, plot_y_q} <= circ_pt(2'd0, px_q, py_q, 8'd0 - rad_q, 8'd0);
                state_q  <= S_RD;
              end
            end
            KIND_FILL: begin
              fill_cnt_q <= '0;
              state_q    <= S_FILL;
            end
            KIND_READ: begin
              if (read_in_range) begin
                state_q <= S_RDATA;
              end else begin
                done_q    <= 1'b1;
                is_read_q <= 1'b1;
                state_q   <= S_IDLE;
              end
            end
            default: begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          endcase
        end
        S_RD: state_q <= plot_off ? S_NEXT : S_WR;
        S_WR: state_q <= S_NEXT;
        S_NEXT: begin
          case (kind_q)
            KIND_LINE, KIND_RECT: begin
              if (first_q) begin
                first_q <= 1'b0;
              end else begin
                ax_q  <= ax_n;
                ay_q  <= ay_n;
                err_q <= err_n;
              end
              if (first_q ? (ax_q == bx_q && ay_q == by_q)
                          : (ax_n == bx_q && ay_n == by_q)) begin
                if (kind_q == KIND_RECT && seg_q != 2'd3) begin
                  // Next side of the rectangle.
                  seg_q    <= seg_n;
                  ax_q     <= sa_x;
                  ay_q     <= sa_y;
                  bx_q     <= sb_x;
                  by_q     <= sb_y;
                  dx_q     <= ld_dx;
                  dy_q     <= ld_dy;
                  sx_q     <= ld_sx;
                  sy_q     <= ld_sy;
                  err_q    <= ld_err;
                  first_q  <= 1'b1;
                  plot_x_q <= sb_x;
                  plot_y_q <= sb_y;
                  state_q  <= S_RD;
                end else begin
                  done_q  <= 1'b1;
                  state_q <= S_IDLE;
                end
              end else begin
                plot_x_q <= first_q ? ax_q : ax_n;
                plot_y_q <= first_q ? ay_q : ay_n;
                state_q  <= S_RD;
              end
            end
            KIND_CIRCLE: begin
              if (quad_q != 2'd3) begin
                quad_q   <= quad_q + 2'd1;
                plot_x_q <= q_x;
                plot_y_q <= q_y;
                state_q  <= S_RD;
              end else begin
                cx_q   <= cx1;
                cy_q   <= cy1;
                cerr_q <= cerr2;
                quad_q <= 2'd0;
                if (cx1 <= 13'sd0) begin
                  plot_x_q <= q0_x;
                  plot_y_q <= q0_y;
                  state_q  <= S_RD;
                end else begin
                  done_q  <= 1'b1;
                  state_q <= S_IDLE;
                end
              end
            end
            default: begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          endcase
        end
        S_FILL: begin
          fill_cnt_q <= fill_cnt_q + AddrW'(1);
          if (fill_cnt_q == AddrW'(StoreBytes - 1)) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_RDATA: begin
          done_q    <= 1'b1;
          is_read_q <= 1'b1;
          rdata_q   <= mem_rd_q;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign is_read_o   = is_read_q;

endmodule

### src/mono_framebuffer_draw_engine_unit.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_unit
// Paged 1-bit-per-pixel framebuffer with pixel, line, rectangle, circle, fill
// and byte read commands.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction  flow
//  command   start_i, busy_o, op_i .. byte_index_i    in         start_i && !busy_o
//  config    invert_color_we_i, invert_color_i        in         write enable
//  result    done_o, read_data_o, is_read_o           out        one-cycle strobe
//
// An item leaves the queue at the earliest in the cycle after it was accepted.
// A pixel then passes start, framebuffer read, write and step states, the
// write skipped off screen; an in-range read passes start and read-data, and an
// unknown op, an out-of-range read or a circle centered off screen ends in start.
// Each line pixel and circle point costs a framebuffer read, write and step, no
// write when off screen; a fill writes one byte per cycle.
// The command queue holds two items; busy_o is high while it is full.
// Reset clears control state only; framebuffer contents are undefined until
// written. Results cannot be stalled.
module mono_framebuffer_draw_engine_unit
  import mfde_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  end_x_i,
  input  logic [7:0]  end_y_i,
  input  logic [7:0]  radius_i,
  input  logic        color_i,
  input  logic [9:0]  byte_index_i,
  input  logic        invert_color_we_i,
  input  logic        invert_color_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        is_read_o
);

  logic invert_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (invert_color_we_i) begin
      invert_q <= invert_color_i;
    end
  end

  mfde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .radius_i     (radius_i),
    .color_i      (color_i),
    .byte_index_i (byte_index_i),
    .busy_o       (busy_o),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  mfde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .invert_i    (invert_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .is_read_o   (is_read_o)
  );

endmodule

### src/mfde_checker.sv
// ----------------------------------------------------------------------------
// mfde_checker
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module mfde_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [7:0] read_data_o,
  input logic       is_read_o
);

  // Result fields stay quiet between strobes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (!is_read_o && read_data_o == 8'h00))
    else $error("result fields active without strobe");

  // Only a read carries data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_read_o) |-> (read_data_o == 8'h00))
    else $error("data on a non-read result");

  // The queue can only fill up after a command was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a command");

endmodule

bind mono_framebuffer_draw_engine_unit mfde_checker u_mfde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .read_data_o (read_data_o),
  .is_read_o   (is_read_o)
);

### sim/mono_framebuffer_draw_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_unit_tb
// Checks the draw engine against its own framebuffer prediction. Commands are
// sent with random gaps, pixel, line, rectangle, circle and fill drawing is mirrored
// in a local copy of the buffer, and every read result is compared with it.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_unit_tb;
  import mfde_pkg::*;

  localparam int unsigned Width   = ScreenWidthDef;
  localparam int unsigned Height  = ScreenHeightDef;
  localparam int unsigned Bytes   = Width * ((Height + 7) / 8);
  localparam int unsigned PerPass = 360;

  class frame_scoreboard;
    bit [7:0] frame[Bytes];
    bit       invert;
    bit [8:0] pending_q[$];
    int       mismatches;

    function void plot(int x, int y, bit color);
      int idx;
      if (x >= Width || y >= Height) return;
      idx = x + (y / 8) * Width;
      if (color ^ invert) frame[idx][y % 8] = 1'b1;
      else frame[idx][y % 8] = 1'b0;
    endfunction

    function void line(bit [7:0] ax, bit [7:0] ay, bit [7:0] bx, bit [7:0] by, bit color);
      int       dx, dy, err, twice;
      bit [7:0] sx, sy;
      dx = (ax < bx) ? bx - ax : ax - bx;
      dy = (ay < by) ? by - ay : ay - by;
      sx = (ax < bx) ? 8'd1 : 8'hFF;
      sy = (ay < by) ? 8'd1 : 8'hFF;
      err = dx - dy;
      plot(bx, by, color);
      while (ax != bx || ay != by) begin
        plot(ax, ay, color);
        twice = err * 2;
        if (twice > -dy) begin
          err -= dy;
          ax = ax + sx;
        end
        if (twice < dx) begin
          err += dx;
          ay = ay + sy;
        end
      end
    endfunction

    function void circle(int cx, int cy, int r, bit color);
      int x, y, err, e2;
      if (cx >= Width || cy >= Height) return;
      x = -r;
      y = 0;
      err = 2 - 2 * r;
      do begin
        plot((cx - x) & 255, (cy + y) & 255, color);
        plot((cx + x) & 255, (cy + y) & 255, color);
        plot((cx + x) & 255, (cy - y) & 255, color);
        plot((cx - x) & 255, (cy - y) & 255, color);
        e2 = err;
        if (e2 <= y) begin
          y++;
          err += y * 2 + 1;
          if (-x == y && e2 <= x) e2 = 0;
        end
        if (e2 > x) begin
          x++;
          err += x * 2 + 1;
        end
      end while (x <= 0);
    endfunction

    function void note_command(bit [2:0] op, bit [7:0] px, bit [7:0] py, bit [7:0] ex,
                               bit [7:0] ey, bit [7:0] r, bit color, bit [9:0] bidx);
      bit [7:0] data;
      bit       rd;
      data = 8'h00;
      rd   = 1'b0;
      case (op)
        OP_PIXEL:  plot(px, py, color);
        OP_LINE:   line(px, py, ex, ey, color);
        OP_CIRCLE: circle(px, py, r, color);
        OP_RECT: begin
          line(px, py, ex, py, color);
          line(ex, py, ex, ey, color);
          line(ex, ey, px, ey, color);
          line(px, ey, px, py, color);
        end
        OP_FILL: foreach (frame[i]) frame[i] = color ? 8'hFF : 8'h00;
        OP_READ: begin
          rd = 1'b1;
          if (bidx < Bytes) data = frame[bidx];
        end
        default: ;
      endcase
      pending_q.push_back({rd, data});
    endfunction

    function void check_result(bit [7:0] data, bit rd);
      bit [8:0] want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result data=%h is_read=%b", data, rd);
        return;
      end
      want = pending_q.pop_front();
      if (want != {rd, data}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected data=%h is_read=%b, got data=%h is_read=%b",
                   want[7:0], want[8], data, rd);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic [2:0] op_i = '0;
  logic [7:0] pos_x_i = '0, pos_y_i = '0, end_x_i = '0, end_y_i = '0, radius_i = '0;
  logic       color_i = 1'b0;
  logic [9:0] byte_index_i = '0;
  logic       invert_color_we_i = 1'b0;
  logic       invert_color_i = 1'b0;
  logic       done_o;
  logic [7:0] read_data_o;
  logic       is_read_o;

  frame_scoreboard board = new();

  mono_framebuffer_draw_engine_unit u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .pos_x_i, .pos_y_i, .end_x_i, .end_y_i,
    .radius_i, .color_i, .byte_index_i, .invert_color_we_i, .invert_color_i,
    .done_o, .read_data_o, .is_read_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000_000;
    $display("FAIL mono_framebuffer_draw_engine_unit");
    $finish;
  end

  // Results are checked before the item accepted at the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) board.check_result(read_data_o, is_read_o);
      if (invert_color_we_i) board.invert = invert_color_i;
      if (start_i && !busy_o)
        board.note_command(op_i, pos_x_i, pos_y_i, end_x_i, end_y_i, radius_i, color_i,
                           byte_index_i);
    end
  end

  task automatic send_cmd(bit [2:0] op, bit [7:0] px, bit [7:0] py, bit [7:0] ex,
                          bit [7:0] ey, bit [7:0] r, bit color, bit [9:0] bidx, int gap);
    op_i <= op;
    pos_x_i <= px;
    pos_y_i <= py;
    end_x_i <= ex;
    end_y_i <= ey;
    radius_i <= r;
    color_i <= color;
    byte_index_i <= bidx;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_invert(bit value);
    drain();
    invert_color_we_i <= 1'b1;
    invert_color_i <= value;
    @(posedge clk_i);
    invert_color_we_i <= 1'b0;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic bit [7:0] pick_coord(int limit);
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, limit - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_cmd();
    int       roll;
    bit [2:0] op;
    bit [7:0] r;
    roll = $urandom_range(0, 99);
    if (roll < 15) op = OP_PIXEL;
    else if (roll < 32) op = OP_LINE;
    else if (roll < 44) op = OP_CIRCLE;
    else if (roll < 54) op = OP_RECT;
    else if (roll < 56) op = OP_FILL;
    else if (roll < 96) op = OP_READ;
    else op = 3'($urandom_range(6, 7));
    r = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 24));
    send_cmd(op, pick_coord(Width), pick_coord(Height), pick_coord(Width), pick_coord(Height),
             r, 1'($urandom_range(0, 1)), 10'($urandom_range(0, Bytes - 1)), pick_gap());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_invert(1'b0);

    // The whole buffer is written first so that no read sees an unwritten byte.
    send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1'b0, 0, 0);
    send_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 1'b1, 0, 0);
    send_cmd(OP_PIXEL, 8'(Width - 1), 8'(Height - 1), 0, 0, 0, 1'b1, 0, 0);
    send_cmd(OP_PIXEL, 8'(Width), 0, 0, 0, 0, 1'b1, 0, 0);
    send_cmd(OP_PIXEL, 255, 255, 255, 255, 255, 1'b1, 10'h3FF, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0, 10'(Bytes - 1), 0);
    send_cmd(OP_LINE, 0, 0, 8'(Width - 1), 8'(Height - 1), 0, 1'b1, 0, 0);
    send_cmd(OP_LINE, 250, 70, 5, 3, 0, 1'b1, 0, 0);
    send_cmd(OP_LINE, 10, 10, 10, 10, 0, 1'b1, 0, 1);
    send_cmd(OP_RECT, 3, 3, 40, 30, 0, 1'b1, 0, 0);
    send_cmd(OP_RECT, 200, 50, 20, 200, 0, 1'b0, 0, 0);
    send_cmd(OP_CIRCLE, 60, 30, 20, 20, 20, 1'b1, 0, 0);
    send_cmd(OP_CIRCLE, 2, 2, 0, 0, 10, 1'b1, 0, 0);
    send_cmd(OP_CIRCLE, 200, 10, 0, 0, 5, 1'b1, 0, 0);
    send_cmd(OP_CIRCLE, 50, 50, 0, 0, 0, 1'b1, 0, 0);
    send_cmd(OP_CIRCLE, 64, 32, 0, 0, 255, 1'b1, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0, 130, 0);
    send_cmd(3'd6, 255, 255, 255, 255, 255, 1'b1, 10'h3FF, 0);
    send_cmd(3'd7, 0, 0, 0, 0, 0, 1'b0, 0, 0);
    send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1'b1, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0, 512, 0);
    set_invert(1'b1);
    send_cmd(OP_PIXEL, 5, 5, 0, 0, 0, 1'b1, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0, 5, 0);

    for (int pass = 0; pass < 4; pass++) begin
      set_invert(pass[0]);
      for (int n = 0; n < PerPass; n++) begin
        if (pass == 1 && n == PerPass / 2) drain();
        random_cmd();
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("PASS mono_framebuffer_draw_engine_unit");
    end else begin
      $display("FAIL mono_framebuffer_draw_engine_unit");
    end
    $finish;
  end

endmodule
